/* src/bts_pkg.sv */
`default_nettype none
package bts_pkg;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_DEF       = 16;
    localparam int CH_W           = 16;
    localparam int TEXEL_W        = 4 * CH_W;
    localparam int SIZE_W         = 9;
    localparam int POS_W          = 8;
    localparam int COORD_W        = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEX_WIDTH  = 2'd0,
        REG_TEX_HEIGHT = 2'd1,
        REG_WRAP_U     = 2'd2,
        REG_WRAP_V     = 2'd3
    } t_cfg_reg;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_WRITE  = 1'b1
    } t_op;

    typedef struct packed {
        logic                  operation;
        logic [POS_W-1:0]      texel_x;
        logic [POS_W-1:0]      texel_y;
        logic [CH_W-1:0]       in_red;
        logic [CH_W-1:0]       in_green;
        logic [CH_W-1:0]       in_blue;
        logic [CH_W-1:0]       in_alpha;
        logic signed [COORD_W-1:0] u_coord;
        logic signed [COORD_W-1:0] v_coord;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic [CH_W-1:0] out_alpha;
    } t_out_word;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_word;
endpackage
`default_nettype wire

/* src/bts_if.sv */
`default_nettype none
interface bts_in_if import bts_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bts_out_if import bts_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bts_cfg_if import bts_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* src/bilinear_texture_sampler.sv */
`default_nettype none
// Bilinear RGBA16 texture sampler. One word per cycle is taken in unless stalled, writes and
// samples alike; a sample's filtered texel passes through address (1), scale (2), texel
// read (3), weight (4), products (5), sum (6) and round (7). The texel store is split into
// four banks by the parity of x and y so that the four neighbours are read in the same cycle;
// the pipeline advances only when the output register is free, so a stall holds every stage.
// Store contents after reset are undefined; sample only texels that were written.
module bilinear_texture_sampler import bts_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int FRAC       = FRAC_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bts_in_if.sink    i_in,
    bts_out_if.source o_out,
    bts_cfg_if.sink   i_cfg
);
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int BXW  = (XW > 1) ? XW - 1 : 1;
    localparam int BYW  = (YW > 1) ? YW - 1 : 1;
    localparam int BD   = (MAX_WIDTH / 2 + 1) * (MAX_HEIGHT / 2 + 1);
    localparam int BAW  = $clog2(BD);
    localparam int MXW  = $clog2(MAX_WIDTH + 1);
    localparam int MYW  = $clog2(MAX_HEIGHT + 1);
    localparam int AW   = FRAC + 1;
    localparam int SUW  = AW + XW;
    localparam int SVW  = AW + YW;
    localparam int WW   = 2 * FRAC + 1;
    localparam int PW   = WW + CH_W;
    localparam int SW   = PW + 2;
    localparam int DEP  = 7;
    localparam logic [AW-1:0] ONE = AW'(1) << FRAC;

    // configuration
    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_wrap_u, r_wrap_v;
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIZE_W'(1);
            r_height <= SIZE_W'(1);
            r_wrap_u <= 1'b0;
            r_wrap_v <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                REG_TEX_WIDTH:  r_width  <= i_cfg.payload.data;
                REG_TEX_HEIGHT: r_height <= i_cfg.payload.data;
                REG_WRAP_U:     r_wrap_u <= i_cfg.payload.data[0];
                REG_WRAP_V:     r_wrap_v <= i_cfg.payload.data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [MXW-1:0] eff_w(input logic [SIZE_W-1:0] r);
        logic [MXW-1:0] v;
        v = MXW'(r);
        if (r == '0) v = MXW'(1);
        else if (32'(r) > MAX_WIDTH) v = MXW'(MAX_WIDTH);
        return v;
    endfunction
    function automatic logic [MYW-1:0] eff_h(input logic [SIZE_W-1:0] r);
        logic [MYW-1:0] v;
        v = MYW'(r);
        if (r == '0) v = MYW'(1);
        else if (32'(r) > MAX_HEIGHT) v = MYW'(MAX_HEIGHT);
        return v;
    endfunction
    logic [MXW-1:0] w_eff;
    logic [MYW-1:0] h_eff;
    assign w_eff = eff_w(r_width);
    assign h_eff = eff_h(r_height);

    function automatic logic [AW-1:0] addr_coord(input logic signed [COORD_W-1:0] x,
                                                 input logic rep);
        logic [AW-1:0] v;
        logic [FRAC-1:0] fr;
        fr = x[FRAC-1:0];
        if (!rep) begin
            if (x < 0) v = '0;
            else if (x > $signed(COORD_W'(ONE))) v = ONE;
            else v = AW'(x);
        end else if (x == 0) v = '0;
        else if (x < 0) v = AW'(fr);
        else if (fr == '0) v = ONE;
        else v = AW'(fr);
        return v;
    endfunction

    logic adv;
    logic [DEP-1:0] r_vld;
    assign adv = !o_out.valid || o_out.ready;
    assign i_in.ready = adv;

    // stage 1: addressing and texel write
    logic [AW-1:0] r1_au, r1_av;
    logic [XW-1:0] r1_wm1;
    logic [YW-1:0] r1_hm1;
    logic [MXW-1:0] r1_w;
    logic [MYW-1:0] r1_h;
    logic r1_ru, r1_rv;
    logic in_smp, in_wr;
    assign in_smp = i_in.valid && adv && (i_in.payload.operation == OP_SAMPLE);
    assign in_wr  = i_in.valid && adv && (i_in.payload.operation == OP_WRITE)
                 && (MXW'(i_in.payload.texel_x) < w_eff)
                 && (MYW'(i_in.payload.texel_y) < h_eff)
                 && (32'(i_in.payload.texel_x) < MAX_WIDTH)
                 && (32'(i_in.payload.texel_y) < MAX_HEIGHT);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_au  <= addr_coord(i_in.payload.u_coord, r_wrap_u);
            r1_av  <= addr_coord(i_in.payload.v_coord, r_wrap_v);
            r1_wm1 <= XW'(w_eff - MXW'(1));
            r1_hm1 <= YW'(h_eff - MYW'(1));
            r1_w   <= w_eff;
            r1_h   <= h_eff;
            r1_ru  <= r_wrap_u;
            r1_rv  <= r_wrap_v;
        end
    end

    // stage 2: scale by size minus one
    logic [SUW-1:0] r2_su;
    logic [SVW-1:0] r2_sv;
    logic [MXW-1:0] r2_w;
    logic [MYW-1:0] r2_h;
    logic r2_ru, r2_rv;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_su <= SUW'(r1_au) * SUW'(r1_wm1);
            r2_sv <= SVW'(r1_av) * SVW'(r1_hm1);
            r2_w  <= r1_w;
            r2_h  <= r1_h;
            r2_ru <= r1_ru;
            r2_rv <= r1_rv;
        end
    end

    // stage 3: neighbour indices and bank reads
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [MXW-1:0] x0n;
    logic [MYW-1:0] y0n;
    always_comb begin
        x0  = r2_su[FRAC +: XW];
        y0  = r2_sv[FRAC +: YW];
        x0n = MXW'(x0) + MXW'(1);
        y0n = MYW'(y0) + MYW'(1);
        x1  = (x0n >= r2_w) ? (r2_ru ? '0 : XW'(r2_w - MXW'(1))) : XW'(x0n);
        y1  = (y0n >= r2_h) ? (r2_rv ? '0 : YW'(r2_h - MYW'(1))) : YW'(y0n);
    end

    function automatic logic [BAW-1:0] baddr(input logic [XW-1:0] x, input logic [YW-1:0] y);
        logic [BXW-1:0] bx;
        logic [BYW-1:0] by;
        bx = BXW'(x >> 1);
        by = BYW'(y >> 1);
        return BAW'(BAW'(by) * BAW'(MAX_WIDTH / 2 + 1) + BAW'(bx));
    endfunction

    // bank b = {y parity, x parity}
    logic [TEXEL_W-1:0] bank0 [BD];
    logic [TEXEL_W-1:0] bank1 [BD];
    logic [TEXEL_W-1:0] bank2 [BD];
    logic [TEXEL_W-1:0] bank3 [BD];
    logic [TEXEL_W-1:0] r3_q [4];
    logic [BAW-1:0] ra [4];
    logic [1:0] wb;
    logic [BAW-1:0] wa;
    logic [TEXEL_W-1:0] wd;
    assign wb = {i_in.payload.texel_y[0], i_in.payload.texel_x[0]};
    assign wa = baddr(XW'(i_in.payload.texel_x), YW'(i_in.payload.texel_y));
    assign wd = {i_in.payload.in_alpha, i_in.payload.in_blue,
                 i_in.payload.in_green, i_in.payload.in_red};
    // a write lands as it leaves stage one, after every older sample has read its texels
    logic r1_wr;
    logic [1:0] r1_wb;
    logic [BAW-1:0] r1_wa;
    logic [TEXEL_W-1:0] r1_wd;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_wr <= 1'b0;
        else if (adv) r1_wr <= in_wr;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_wb <= wb;
            r1_wa <= wa;
            r1_wd <= wd;
        end
    end
    // ra[b] addresses the corner that falls in bank b
    logic [XW-1:0] xe, xo;
    logic [YW-1:0] ye, yo;
    logic sx, sy;
    always_comb begin
        xe = x0[0] ? x1 : x0;
        xo = x0[0] ? x0 : x1;
        ye = y0[0] ? y1 : y0;
        yo = y0[0] ? y0 : y1;
        ra[0] = baddr(xe, ye);
        ra[1] = baddr(xo, ye);
        ra[2] = baddr(xe, yo);
        ra[3] = baddr(xo, yo);
    end
    always_ff @(posedge i_clk) begin
        if (adv && r1_wr && r1_wb == 2'd0) bank0[r1_wa] <= r1_wd;
        if (adv && r1_wr && r1_wb == 2'd1) bank1[r1_wa] <= r1_wd;
        if (adv && r1_wr && r1_wb == 2'd2) bank2[r1_wa] <= r1_wd;
        if (adv && r1_wr && r1_wb == 2'd3) bank3[r1_wa] <= r1_wd;
        if (adv) begin
            r3_q[0] <= bank0[ra[0]];
            r3_q[1] <= bank1[ra[1]];
            r3_q[2] <= bank2[ra[2]];
            r3_q[3] <= bank3[ra[3]];
        end
    end
    logic [FRAC-1:0] r3_fx, r3_fy;
    logic r3_sx, r3_sy, r3_dx, r3_dy;
    assign sx = x0[0];
    assign sy = y0[0];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_fx <= r2_su[FRAC-1:0];
            r3_fy <= r2_sv[FRAC-1:0];
            r3_sx <= sx;
            r3_sy <= sy;
            // a neighbour equal to its base sits in the same bank
            r3_dx <= (x1 == x0);
            r3_dy <= (y1 == y0);
        end
    end

    // stage 4: pick corners, form weights
    logic [TEXEL_W-1:0] t00, t10, t01, t11;
    logic [AW-1:0] ofx, ofy;
    always_comb begin
        logic [1:0] b00, b10, b01, b11;
        b00 = {r3_sy, r3_sx};
        b10 = {r3_sy, r3_dx ? r3_sx : ~r3_sx};
        b01 = {r3_dy ? r3_sy : ~r3_sy, r3_sx};
        b11 = {r3_dy ? r3_sy : ~r3_sy, r3_dx ? r3_sx : ~r3_sx};
        t00 = r3_q[b00];
        t10 = r3_q[b10];
        t01 = r3_q[b01];
        t11 = r3_q[b11];
        ofx = ONE - AW'(r3_fx);
        ofy = ONE - AW'(r3_fy);
    end
    logic [TEXEL_W-1:0] r4_t [4];
    logic [WW-1:0] r4_w [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_t[0] <= t00;
            r4_t[1] <= t10;
            r4_t[2] <= t01;
            r4_t[3] <= t11;
            r4_w[0] <= WW'(WW'(ofx) * WW'(ofy));
            r4_w[1] <= WW'(WW'(r3_fx) * WW'(ofy));
            r4_w[2] <= WW'(WW'(ofx) * WW'(r3_fy));
            r4_w[3] <= WW'(WW'(r3_fx) * WW'(r3_fy));
        end
    end

    // stage 5: products, 16 of them
    logic [PW-1:0] r5_p [4][4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++)
                for (int k = 0; k < 4; k++)
                    r5_p[c][k] <= PW'(r4_t[k][c*CH_W +: CH_W]) * PW'(r4_w[k]);
        end
    end

    // stage 6: sum
    logic [SW-1:0] r6_s [4];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int c = 0; c < 4; c++)
                r6_s[c] <= SW'(r5_p[c][0]) + SW'(r5_p[c][1])
                         + SW'(r5_p[c][2]) + SW'(r5_p[c][3]);
        end
    end

    // stage 7: round half to even, into the output register
    function automatic logic [CH_W-1:0] rnd(input logic [SW-1:0] a);
        logic [SW-2*FRAC-1:0] q;
        logic [2*FRAC-1:0] r;
        logic [2*FRAC-1:0] half;
        half = (2*FRAC)'(1) << (2*FRAC - 1);
        q = a[SW-1:2*FRAC];
        r = a[2*FRAC-1:0];
        if (r > half || (r == half && q[0])) q = q + 1'b1;
        if (q > (SW-2*FRAC)'(16'hFFFF)) q = (SW-2*FRAC)'(16'hFFFF);
        return CH_W'(q);
    endfunction
    t_out_word r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_red   <= rnd(r6_s[0]);
            r_out.out_green <= rnd(r6_s[1]);
            r_out.out_blue  <= rnd(r6_s[2]);
            r_out.out_alpha <= rnd(r6_s[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (adv) r_vld <= {r_vld[DEP-2:0], in_smp};
    end
    assign o_out.valid   = r_vld[DEP-1];
    assign o_out.payload = r_out;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(r_vld))
        else $error("pipeline moved under stall");
    a_noout_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_wr) |-> !in_smp)
        else $error("write counted as sample");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !in_smp) |=> !r_vld[0])
        else $error("stage one valid without sample");
endmodule
`default_nettype wire
